/* rtl/core/tws_pkg.sv */
`timescale 1ns / 1ps

package tws_pkg;

    localparam int DEPTH     = 16;
    localparam int STAMP_W   = 64;
    localparam int PAY_W     = 16;
    localparam int OUT_CNT_W = 5;
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int IDX_W     = $clog2(DEPTH);

    typedef struct packed {
        logic insert;
        logic flag;
    } t_cell_ctrl;

    // saturating add, clamps at all ones
    function automatic logic [STAMP_W-1:0] sat_add(input logic [STAMP_W-1:0] a,
                                                   input logic [STAMP_W-1:0] b);
        logic [STAMP_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[STAMP_W] ? {STAMP_W{1'b1}} : s[STAMP_W-1:0];
    endfunction

endpackage

/* rtl/core/tws_cell.sv */
`timescale 1ns / 1ps

module tws_cell import tws_pkg::*; (
    input  logic               i_clk,
    input  t_cell_ctrl         i_ctrl,
    input  logic               i_occ,
    input  logic [STAMP_W-1:0] i_new_stamp,
    input  logic [PAY_W-1:0]   i_new_payload,
    input  logic               i_left_gt,
    input  logic [STAMP_W-1:0] i_left_stamp,
    input  logic [PAY_W-1:0]   i_left_payload,
    input  logic [STAMP_W-1:0] i_max_age,
    input  logic [STAMP_W-1:0] i_newest,
    output logic               o_gt,
    output logic [STAMP_W-1:0] o_stamp,
    output logic [PAY_W-1:0]   o_payload,
    output logic               o_prune
);

    logic [STAMP_W-1:0] r_stamp, n_stamp;
    logic [PAY_W-1:0]   r_payload, n_payload;
    logic               r_prune, n_prune;

    assign o_gt      = i_occ && (r_stamp > i_new_stamp);
    assign o_stamp   = r_stamp;
    assign o_payload = r_payload;
    assign o_prune   = r_prune;

    always_comb begin
        n_stamp   = r_stamp;
        n_payload = r_payload;
        n_prune   = r_prune;
        // an older-or-equal entry makes way: new item lands at the boundary,
        // the rest take their left neighbour
        if (i_ctrl.insert && !o_gt) begin
            if (i_left_gt) begin
                n_stamp   = i_new_stamp;
                n_payload = i_new_payload;
            end else begin
                n_stamp   = i_left_stamp;
                n_payload = i_left_payload;
            end
        end
        if (i_ctrl.flag) begin
            n_prune = sat_add(r_stamp, i_max_age) < i_newest;
        end
    end

    always_ff @(posedge i_clk) begin
        r_stamp   <= n_stamp;
        r_payload <= n_payload;
        r_prune   <= n_prune;
    end

endmodule

/* rtl/core/time_window_sorted_buffer.sv */
`timescale 1ns / 1ps

// Sorted sliding-window store of up to DEPTH timestamped items, newest first.
// Input: start with i_stamp/i_payload, taken on a rising edge while busy
// is low. Configuration: i_cfg_we/i_cfg_wdata write max_age; the user must
// write it only when idle, which the block itself does not enforce. Output:
// one result per item, held for exactly one cycle under o_strobe;
// the receiver cannot stall and must take it in that cycle.
// Flow: a rejected item reports straight from S_INSERT, where the strobe is
// registered. An accepted item passes S_INSERT, the insert shift along the
// cell chain, then S_FLAG, where every cell checks its own age against the
// newest stamp, then S_PRUNE, which pops the tail once per pruned entry
// (k = entries pruned, 0 to DEPTH-1) and then reports. A new item may start
// in the strobe cycle.
// Reset clears the fill count and max_age goes back to 1e9; the cell
// contents are left as they are and are never read while unoccupied.
module time_window_sorted_buffer import tws_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [STAMP_W-1:0]   i_cfg_wdata,
    input  logic                 start,
    input  logic [STAMP_W-1:0]   i_stamp,
    input  logic [PAY_W-1:0]     i_payload,
    output logic                 busy,
    output logic                 o_strobe,
    output logic                 o_accepted,
    output logic                 o_evicted,
    output logic [OUT_CNT_W-1:0] o_pruned,
    output logic [OUT_CNT_W-1:0] o_entries,
    output logic [STAMP_W-1:0]   o_newest_stamp,
    output logic [STAMP_W-1:0]   o_oldest_stamp,
    output logic [PAY_W-1:0]     o_newest_payload
);

    typedef enum logic [1:0] {S_IDLE, S_INSERT, S_FLAG, S_PRUNE} t_state;

    t_state             r_state;
    logic [STAMP_W-1:0] r_max_age;
    logic [STAMP_W-1:0] r_new_stamp;
    logic [PAY_W-1:0]   r_new_payload;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   r_pruned;
    logic               r_evicted;

    logic               r_strobe, r_accepted, r_evicted_o;
    logic [OUT_CNT_W-1:0] r_pruned_o, r_entries_o;
    logic [STAMP_W-1:0] r_newest_o, r_oldest_o;
    logic [PAY_W-1:0]   r_newest_pay_o;

    logic [STAMP_W-1:0] w_stamp   [DEPTH];
    logic [PAY_W-1:0]   w_payload [DEPTH];
    logic [DEPTH-1:0]   w_gt, w_prune, w_occ;
    logic [CNT_W-1:0]   w_eff_count;
    logic [IDX_W-1:0]   w_tail;
    logic               w_accept, w_pop;
    t_cell_ctrl         w_ctrl;

    // a full store drops its tail before the position search
    assign w_eff_count = (r_count == CNT_W'(DEPTH)) ? CNT_W'(DEPTH - 1) : r_count;
    assign w_tail      = IDX_W'(r_count - 1'b1);
    assign w_accept    = !((r_count != '0) &&
                           (w_stamp[0] > sat_add(r_new_stamp, r_max_age)));
    assign w_pop       = (r_count != '0) && w_prune[w_tail];
    assign w_ctrl.insert = (r_state == S_INSERT) && w_accept;
    assign w_ctrl.flag   = (r_state == S_FLAG);

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            logic               left_gt;
            logic [STAMP_W-1:0] left_stamp;
            logic [PAY_W-1:0]   left_payload;

            assign w_occ[gi] = CNT_W'(gi) < w_eff_count;

            if (gi == 0) begin : g_head
                assign left_gt      = 1'b1;
                assign left_stamp   = r_new_stamp;
                assign left_payload = r_new_payload;
            end else begin : g_body
                assign left_gt      = w_gt[gi-1];
                assign left_stamp   = w_stamp[gi-1];
                assign left_payload = w_payload[gi-1];
            end

            tws_cell u_cell (
                .i_clk          (i_clk),
                .i_ctrl         (w_ctrl),
                .i_occ          (w_occ[gi]),
                .i_new_stamp    (r_new_stamp),
                .i_new_payload  (r_new_payload),
                .i_left_gt      (left_gt),
                .i_left_stamp   (left_stamp),
                .i_left_payload (left_payload),
                .i_max_age      (r_max_age),
                .i_newest       (w_stamp[0]),
                .o_gt           (w_gt[gi]),
                .o_stamp        (w_stamp[gi]),
                .o_payload      (w_payload[gi]),
                .o_prune        (w_prune[gi])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_max_age <= STAMP_W'(64'd1000000000);
            r_count   <= '0;
            r_strobe  <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            if (i_cfg_we) begin
                r_max_age <= i_cfg_wdata;
            end
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_new_stamp   <= i_stamp;
                        r_new_payload <= i_payload;
                        r_pruned      <= '0;
                        r_state       <= S_INSERT;
                    end
                end
                S_INSERT: begin
                    if (w_accept) begin
                        r_evicted <= (r_count == CNT_W'(DEPTH));
                        r_count   <= w_eff_count + 1'b1;
                        r_state   <= S_FLAG;
                    end else begin
                        r_strobe       <= 1'b1;
                        r_accepted     <= 1'b0;
                        r_evicted_o    <= 1'b0;
                        r_pruned_o     <= '0;
                        r_entries_o    <= OUT_CNT_W'(r_count);
                        r_newest_o     <= (r_count != '0) ? w_stamp[0] : '0;
                        r_oldest_o     <= (r_count != '0) ? w_stamp[w_tail] : '0;
                        r_newest_pay_o <= (r_count != '0) ? w_payload[0] : '0;
                        r_state        <= S_IDLE;
                    end
                end
                S_FLAG: begin
                    r_state <= S_PRUNE;
                end
                S_PRUNE: begin
                    if (w_pop) begin
                        r_count  <= r_count - 1'b1;
                        r_pruned <= r_pruned + 1'b1;
                    end else begin
                        r_strobe       <= 1'b1;
                        r_accepted     <= 1'b1;
                        r_evicted_o    <= r_evicted;
                        r_pruned_o     <= OUT_CNT_W'(r_pruned);
                        r_entries_o    <= OUT_CNT_W'(r_count);
                        r_newest_o     <= (r_count != '0) ? w_stamp[0] : '0;
                        r_oldest_o     <= (r_count != '0) ? w_stamp[w_tail] : '0;
                        r_newest_pay_o <= (r_count != '0) ? w_payload[0] : '0;
                        r_state        <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy             = (r_state != S_IDLE);
    assign o_strobe         = r_strobe;
    assign o_accepted       = r_accepted;
    assign o_evicted        = r_evicted_o;
    assign o_pruned         = r_pruned_o;
    assign o_entries        = r_entries_o;
    assign o_newest_stamp   = r_newest_o;
    assign o_oldest_stamp   = r_oldest_o;
    assign o_newest_payload = r_newest_pay_o;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("fill count beyond depth");

    a_pop_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PRUNE && w_pop) |=> (r_count == $past(r_count) - 1'b1))
        else $error("prune pop did not decrement fill count");

    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe |-> (r_state == S_IDLE))
        else $error("result strobe while busy");

    a_reject_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && !r_accepted) |-> (!r_evicted_o && r_pruned_o == '0))
        else $error("rejected item reports eviction or pruning");

endmodule

/* test/tws_window_checker.sv */
`timescale 1ns / 1ps

module tws_window_checker import tws_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [STAMP_W-1:0]   i_cfg_wdata,
    input  logic                 i_start,
    input  logic                 i_busy,
    input  logic [STAMP_W-1:0]   i_stamp,
    input  logic [PAY_W-1:0]     i_payload,
    input  logic                 i_strobe,
    input  logic                 i_accepted,
    input  logic                 i_evicted,
    input  logic [OUT_CNT_W-1:0] i_pruned,
    input  logic [OUT_CNT_W-1:0] i_entries,
    input  logic [STAMP_W-1:0]   i_newest_stamp,
    input  logic [STAMP_W-1:0]   i_oldest_stamp,
    input  logic [PAY_W-1:0]     i_newest_payload,
    output int                   o_fail_count,
    output int                   o_pending
);

    localparam logic [STAMP_W-1:0] RESET_WINDOW_NS = 64'd1000000000;

    typedef struct packed {
        logic                 accepted;
        logic                 evicted;
        logic [OUT_CNT_W-1:0] pruned;
        logic [OUT_CNT_W-1:0] entries;
        logic [STAMP_W-1:0]   newest;
        logic [STAMP_W-1:0]   oldest;
        logic [PAY_W-1:0]     newest_pay;
    } t_window_result;

    // predicted store, newest first
    logic [STAMP_W-1:0] held_stamp [DEPTH];
    logic [PAY_W-1:0]   held_pay [DEPTH];
    int                 held_count = 0;
    logic [STAMP_W-1:0] window_ns = RESET_WINDOW_NS;

    t_window_result     due_results [$];
    t_window_result     seen_result;
    t_window_result     want_result;
    int                 fails = 0;
    int                 result_no = 0;

    function automatic logic [STAMP_W-1:0] clamp_sum(input logic [STAMP_W-1:0] a,
                                                     input logic [STAMP_W-1:0] b);
        logic [STAMP_W-1:0] s;
        s = a + b;
        return (s < a) ? '1 : s;
    endfunction

    function automatic t_window_result insert_entry(input logic [STAMP_W-1:0] stamp,
                                                    input logic [PAY_W-1:0] pay);
        t_window_result r;
        int pos;
        int k;
        r = '0;
        if (!(held_count > 0 && held_stamp[0] > clamp_sum(stamp, window_ns))) begin
            r.accepted = 1'b1;
            if (held_count >= DEPTH) begin
                held_count = DEPTH - 1;
                r.evicted = 1'b1;
            end
            pos = 0;
            // equal stamps: new item lands on the newer side
            while (pos < held_count && held_stamp[pos] > stamp)
                pos++;
            for (k = held_count; k > pos; k--) begin
                held_stamp[k] = held_stamp[k-1];
                held_pay[k]   = held_pay[k-1];
            end
            held_stamp[pos] = stamp;
            held_pay[pos]   = pay;
            held_count++;
            while (held_count > 0 &&
                   clamp_sum(held_stamp[held_count-1], window_ns) < held_stamp[0]) begin
                held_count--;
                r.pruned++;
            end
        end
        r.entries = OUT_CNT_W'(held_count);
        if (held_count > 0) begin
            r.newest     = held_stamp[0];
            r.oldest     = held_stamp[held_count-1];
            r.newest_pay = held_pay[0];
        end
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t ns: result %0d: %s", $time, result_no, msg);
        fails++;
    endtask

    task automatic compare_result(input t_window_result got, input t_window_result want);
        if (got.accepted !== want.accepted)
            report_mismatch($sformatf("accepted %0b, expected %0b",
                                      got.accepted, want.accepted));
        if (got.evicted !== want.evicted)
            report_mismatch($sformatf("evicted %0b, expected %0b",
                                      got.evicted, want.evicted));
        if (got.pruned !== want.pruned)
            report_mismatch($sformatf("pruned %0d, expected %0d", got.pruned, want.pruned));
        if (got.entries !== want.entries)
            report_mismatch($sformatf("entries %0d, expected %0d",
                                      got.entries, want.entries));
        if (got.newest !== want.newest)
            report_mismatch($sformatf("newest stamp %0h, expected %0h",
                                      got.newest, want.newest));
        if (got.oldest !== want.oldest)
            report_mismatch($sformatf("oldest stamp %0h, expected %0h",
                                      got.oldest, want.oldest));
        if (got.newest_pay !== want.newest_pay)
            report_mismatch($sformatf("newest payload %0h, expected %0h",
                                      got.newest_pay, want.newest_pay));
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            held_count = 0;
            window_ns  = RESET_WINDOW_NS;
            due_results.delete();
        end else begin
            if (i_cfg_we)
                window_ns = i_cfg_wdata;
            // compare before queueing, so an item taken in a strobe cycle stays in order
            if (i_strobe === 1'b1) begin
                seen_result = '{i_accepted, i_evicted, i_pruned, i_entries,
                                i_newest_stamp, i_oldest_stamp, i_newest_payload};
                if (due_results.size() == 0) begin
                    report_mismatch("result with no item outstanding");
                end else begin
                    want_result = due_results.pop_front();
                    compare_result(seen_result, want_result);
                end
                result_no++;
            end
            if (i_start && i_busy === 1'b0)
                due_results.push_back(insert_entry(i_stamp, i_payload));
        end
        o_fail_count <= fails;
        o_pending    <= due_results.size();
    end

endmodule

/* test/time_window_sorted_buffer_test.sv */
`timescale 1ns / 1ps

module time_window_sorted_buffer_test;
    import tws_pkg::*;

    localparam int CYCLE_LIMIT     = 300000;
    localparam int SETTLE_CYCLES   = DEPTH + 8;
    localparam int PHASE_COUNT     = 9;
    localparam int ITEMS_PER_PHASE = 147;
    localparam int GAP_CHUNK       = 21;
    localparam int MAX_GAP         = 17;
    localparam logic [STAMP_W-1:0] DEFAULT_WINDOW = 64'd1000000000;
    localparam logic [STAMP_W-1:0] REACH_CAP      = 64'h0001_0000_0000_0000;
    localparam logic [STAMP_W-1:0] JUMP_CEILING   = 64'h0100_0000_0000_0000;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [STAMP_W-1:0]   i_cfg_wdata;
    logic                 start;
    logic [STAMP_W-1:0]   i_stamp;
    logic [PAY_W-1:0]     i_payload;
    logic                 busy;
    logic                 o_strobe;
    logic                 o_accepted;
    logic                 o_evicted;
    logic [OUT_CNT_W-1:0] o_pruned;
    logic [OUT_CNT_W-1:0] o_entries;
    logic [STAMP_W-1:0]   o_newest_stamp;
    logic [STAMP_W-1:0]   o_oldest_stamp;
    logic [PAY_W-1:0]     o_newest_payload;

    int                   fail_count;
    int                   pending_count;
    int                   cycle_count = 0;
    int                   items_sent;
    int                   gap_mode;
    logic [STAMP_W-1:0]   cur_window;
    logic [STAMP_W-1:0]   stream_head;
    logic [STAMP_W-1:0]   phase_window [PHASE_COUNT];

    time_window_sorted_buffer i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .start            (start),
        .i_stamp          (i_stamp),
        .i_payload        (i_payload),
        .busy             (busy),
        .o_strobe         (o_strobe),
        .o_accepted       (o_accepted),
        .o_evicted        (o_evicted),
        .o_pruned         (o_pruned),
        .o_entries        (o_entries),
        .o_newest_stamp   (o_newest_stamp),
        .o_oldest_stamp   (o_oldest_stamp),
        .o_newest_payload (o_newest_payload)
    );

    tws_window_checker i_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_start          (start),
        .i_busy           (busy),
        .i_stamp          (i_stamp),
        .i_payload        (i_payload),
        .i_strobe         (o_strobe),
        .i_accepted       (o_accepted),
        .i_evicted        (o_evicted),
        .i_pruned         (o_pruned),
        .i_entries        (o_entries),
        .i_newest_stamp   (o_newest_stamp),
        .i_oldest_stamp   (o_oldest_stamp),
        .i_newest_payload (o_newest_payload),
        .o_fail_count     (fail_count),
        .o_pending        (pending_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles, %0d results outstanding",
                     cycle_count, pending_count);
            $display("FAIL");
            $finish;
        end
    end

    function automatic logic [STAMP_W-1:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // uniform-ish value in 0..span
    function automatic logic [STAMP_W-1:0] bounded(input logic [STAMP_W-1:0] span);
        if (span == '1)
            return rand64();
        return rand64() % (span + 1);
    endfunction

    function automatic logic [STAMP_W-1:0] bump(input logic [STAMP_W-1:0] a,
                                                input logic [STAMP_W-1:0] b);
        logic [STAMP_W-1:0] s;
        s = a + b;
        return (s < a) ? '1 : s;
    endfunction

    function automatic int draw_gap();
        case (gap_mode)
            0: return 0;
            1: return $urandom_range(0, MAX_GAP);
            default: return ($urandom_range(0, 7) == 0) ? $urandom_range(1, MAX_GAP) : 0;
        endcase
    endfunction

    // The stored newest stamp never goes down, so the stream climbs slowly from
    // stream_head; out-of-window items are noise and get rejected.
    function automatic logic [STAMP_W-1:0] pick_stamp();
        logic [STAMP_W-1:0] reach;
        logic [STAMP_W-1:0] lag;
        logic [STAMP_W-1:0] s;
        int kind;
        reach = cur_window >> $urandom_range(1, 8);
        if (reach > REACH_CAP)
            reach = REACH_CAP;
        kind = $urandom_range(0, 99);
        if (kind < 30) begin
            s = bump(stream_head, STAMP_W'($urandom_range(0, 3)));
        end else if (kind < 52) begin
            s = bump(stream_head, bounded(reach));
        end else if (kind < 68) begin
            s = stream_head - bounded(stream_head < reach ? stream_head : reach);
        end else if (kind < 74) begin
            s = stream_head;
        end else if (kind < 78) begin
            s = (stream_head >= cur_window) ? stream_head - cur_window : '0;
        end else if (kind < 90) begin
            if (stream_head > cur_window) begin
                lag = stream_head - cur_window - 1;
                if ($urandom_range(0, 1))
                    s = lag - bounded(lag < reach ? lag : reach);
                else
                    s = bounded(lag);
            end else begin
                s = bounded(stream_head);
            end
        end else if (cur_window < JUMP_CEILING) begin
            s = bump(bump(stream_head, cur_window), 1 + bounded(reach));
        end else begin
            s = bump(stream_head, bounded(reach));
        end
        if (s > stream_head)
            stream_head = s;
        return s;
    endfunction

    task automatic send_item(input logic [STAMP_W-1:0] stamp, input logic [PAY_W-1:0] pay,
                             input int gap);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start     <= 1'b1;
        i_stamp   <= stamp;
        i_payload <= pay;
        do @(posedge i_clk); while (busy !== 1'b0);
        items_sent++;
    endtask

    // hold off until every outstanding result is back and the block is idle
    task automatic settle();
        start <= 1'b0;
        do @(posedge i_clk); while (pending_count != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_window(input logic [STAMP_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cur_window  = value;
    endtask

    initial begin
        int p;
        int n;
        int k;

        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_wdata = '0;
        start       = 1'b0;
        i_stamp     = '0;
        i_payload   = '0;
        items_sent  = 0;
        gap_mode    = 1;
        cur_window  = DEFAULT_WINDOW;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // opening run, narrow window
        write_window(64'd100);
        send_item(64'd0, 16'h0000, draw_gap());      // into the empty store
        send_item(64'd0, 16'hFFFF, draw_gap());      // equal stamp goes newer side
        send_item(64'd50, 16'h1234, draw_gap());
        send_item(64'd30, 16'hA5A5, draw_gap());     // lands mid-store
        send_item(64'd200, 16'h5A5A, draw_gap());    // prunes all four older
        send_item(64'd99, 16'h0001, draw_gap());     // one past the window: rejected
        send_item(64'd100, 16'h8000, draw_gap());    // exactly on the window edge
        for (k = 201; k <= 215; k++)
            send_item(STAMP_W'(k), PAY_W'($urandom_range(0, 16'hFFFF)),
                      draw_gap());  // fill the store to DEPTH entries
        settle();
        // widest window: every sum reaches all ones; 216 evicts from the full store
        write_window('1);
        send_item(64'd216, 16'h7FFF, draw_gap());
        send_item(64'd0, 16'hC3C3, draw_gap());
        stream_head = 64'd216;

        phase_window[0] = DEFAULT_WINDOW;
        phase_window[1] = STAMP_W'($urandom_range(0, 1000));
        phase_window[2] = '0;
        phase_window[3] = 64'd1;
        phase_window[4] = 64'd5000;
        phase_window[5] = {32'h0, $urandom()};
        phase_window[6] = rand64();
        phase_window[7] = '1;
        phase_window[8] = DEFAULT_WINDOW;

        for (p = 0; p < PHASE_COUNT; p++) begin
            settle();
            write_window(phase_window[p]);
            for (n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (n % GAP_CHUNK == 0)
                    gap_mode = $urandom_range(0, 2);
                send_item(pick_stamp(), PAY_W'($urandom_range(0, 16'hFFFF)), draw_gap());
            end
        end

        // closing run at the top of the stamp range
        settle();
        write_window(64'd100);
        gap_mode = 1;
        send_item('1 - 64'd10, 16'hFFFF, draw_gap());   // prunes everything else
        send_item('1 - 64'd150, 16'h0F0F, draw_gap());  // rejected
        send_item('1, 16'h0000, draw_gap());
        send_item('1, 16'hF0F0, draw_gap());

        settle();
        $display("Sent %0d items over %0d window settings, zero, one and all-ones included.",
                 items_sent, PHASE_COUNT + 3);
        $display("Covered equal stamps, rejection, window-edge hits, eviction, pruning, "
                 , "saturated sums and random sender gaps.");
        if (fail_count == 0 && pending_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
